/* src/transactional_key_value_store_macros.svh */
// Assertion helpers used by the store's top module.
`ifndef TRANSACTIONAL_KEY_VALUE_STORE_MACROS_SVH
`define TRANSACTIONAL_KEY_VALUE_STORE_MACROS_SVH

// Plain property, sampled on clk_i, off during reset.
`define TKVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define TKVS_ASSERT_IMP(lbl, ante, cons, msg) \
  `TKVS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define TKVS_ASSERT_NXT(lbl, ante, cons, msg) \
  `TKVS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* src/tkvs_pkg.sv */
package tkvs_pkg;

  localparam int unsigned ENTRIES_DEF  = 16;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned VALUE_BITS   = 32;
  localparam int unsigned KIND_BITS    = 3;
  localparam int unsigned STATUS_BITS  = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_GET      = 3'd0,
    KIND_PUT      = 3'd1,
    KIND_BEGIN    = 3'd2,
    KIND_COMMIT   = 3'd3,
    KIND_ROLLBACK = 3'd4
  } tkvs_kind_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_TXN = 2'd1,
    STAT_IN_TXN = 2'd2,
    STAT_FULL   = 2'd3
  } tkvs_status_e;

  // Search token walking down the chain, one cell per cycle.
  typedef struct packed {
    logic live;
    logic put;
    logic hit;
    logic hit_cv;
    logic free_found;
  } tkvs_tok_t;

  // Broadcast to every cell at once.
  typedef struct packed {
    logic commit;
    logic drop;
    logic wr_new;
  } tkvs_bcast_t;

endpackage

/* src/transactional_key_value_store.sv */
// Transactional key/value store with ENTRIES slots, built as a chain of
// identical cells, each holding one key with a committed and a staged value.
// Commands arrive as one transaction each (tuser = kind: 0 get, 1 put,
// 2 begin, 3 commit, 4 rollback) and every command returns exactly one
// result transaction. Get, and put inside an open transaction, send a
// search token down the chain, one cell per clock; when it leaves the last
// cell the result goes to the holding register and then to the output
// register, and only then is the next command taken. Begin, commit,
// rollback, a put with no open transaction and unused kinds skip the chain;
// begin, commit and rollback act on all cells at once, and the result goes
// straight to the holding register and then to the output register. The
// chain holds one command at a time. Results sit in an output register, so
// the next command is taken while an earlier result still waits; a second
// finished result then waits in the holding register and the input stays
// closed until the first one leaves. Only the low KEY_BITS bits of the key
// count. No clearing pass is needed after reset: valid flags clear at once.
module transactional_key_value_store #(
  parameter int unsigned ENTRIES  = tkvs_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = tkvs_pkg::KEY_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command: tdata = key [31:0], value [63:32]; tuser = kind [2:0]
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [63:0]                       s_axis_tdata_i,
  input  logic [tkvs_pkg::KIND_BITS-1:0]    s_axis_tuser_i,
  // result: tdata = read_value [31:0]; tuser = found [0], status [2:1]
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [tkvs_pkg::VALUE_BITS-1:0]   m_axis_tdata_o,
  output logic [tkvs_pkg::STATUS_BITS:0]    m_axis_tuser_o
);
  import tkvs_pkg::*;
  `include "transactional_key_value_store_macros.svh"

  localparam int unsigned IW = $clog2(ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic                   in_txn_q;
  logic                   res_found_q;
  logic [VALUE_BITS-1:0]  res_rd_q;
  tkvs_status_e           res_status_q;
  logic                   out_valid_q;
  logic                   out_found_q;
  logic [VALUE_BITS-1:0]  out_rd_q;
  tkvs_status_e           out_status_q;

  tkvs_tok_t              tok_w   [ENTRIES+1];
  logic [KEY_BITS-1:0]    key_w   [ENTRIES+1];
  logic [VALUE_BITS-1:0]  value_w [ENTRIES+1];
  logic [VALUE_BITS-1:0]  rd_w    [ENTRIES+1];
  logic [IW-1:0]          idx_w   [ENTRIES+1];

  tkvs_bcast_t            bc;
  tkvs_kind_e             kind;
  logic                   s_accept, walk_cmd, out_free;
  logic [KEY_BITS-1:0]    key_in;
  tkvs_tok_t              tok_end;

  assign kind            = tkvs_kind_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;

  // key narrowed or widened to the stored key width
  if (KEY_BITS >= KEY_W) begin : g_key_wide
    assign key_in = KEY_BITS'(s_axis_tdata_i[KEY_W-1:0]);
  end else begin : g_key_narrow
    assign key_in = s_axis_tdata_i[KEY_BITS-1:0];
  end

  // get always walks; put walks only inside a transaction
  assign walk_cmd = (kind == KIND_GET) || ((kind == KIND_PUT) && in_txn_q);

  always_comb begin
    tok_w[0]      = '0;
    tok_w[0].live = s_accept & walk_cmd;
    tok_w[0].put  = (kind == KIND_PUT);
  end
  assign key_w[0]   = key_in;
  assign value_w[0] = s_axis_tdata_i[KEY_W +: VALUE_BITS];
  assign rd_w[0]    = '0;
  assign idx_w[0]   = '0;

  assign tok_end = tok_w[ENTRIES];

  // broadcast controls
  always_comb begin
    bc.commit = s_accept & (kind == KIND_COMMIT) & in_txn_q;
    bc.drop   = s_accept & in_txn_q & (kind == KIND_ROLLBACK);
    bc.drop   = bc.drop | (s_accept & ~in_txn_q & (kind == KIND_BEGIN));
    bc.wr_new = tok_end.live & tok_end.put & ~tok_end.hit & tok_end.free_found;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_chain
    tkvs_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX_BITS (IW),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok_w[i]),
      .key_i      (key_w[i]),
      .value_i    (value_w[i]),
      .rd_i       (rd_w[i]),
      .free_idx_i (idx_w[i]),
      .tok_o      (tok_w[i+1]),
      .key_o      (key_w[i+1]),
      .value_o    (value_w[i+1]),
      .rd_o       (rd_w[i+1]),
      .free_idx_o (idx_w[i+1]),
      .bc_i       (bc),
      .wr_idx_i   (idx_w[ENTRIES]),
      .wr_key_i   (key_w[ENTRIES]),
      .wr_value_i (value_w[ENTRIES])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      in_txn_q     <= 1'b0;
      res_found_q  <= 1'b0;
      res_rd_q     <= '0;
      res_status_q <= STAT_OK;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_rd_q     <= '0;
      out_status_q <= STAT_OK;
    end else begin
      // ST_DONE reloads the output register itself
      if (out_valid_q && m_axis_tready_i && (state_q != ST_DONE)) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            res_found_q  <= 1'b0;
            res_rd_q     <= '0;
            res_status_q <= STAT_OK;
            state_q      <= ST_DONE;
            unique case (kind)
              KIND_GET: begin
                state_q <= ST_WALK;
              end
              KIND_PUT: begin
                if (in_txn_q) state_q <= ST_WALK;
                else res_status_q <= STAT_NO_TXN;
              end
              KIND_BEGIN: begin
                if (in_txn_q) res_status_q <= STAT_IN_TXN;
                else in_txn_q <= 1'b1;
              end
              KIND_COMMIT, KIND_ROLLBACK: begin
                if (in_txn_q) in_txn_q <= 1'b0;
                else res_status_q <= STAT_NO_TXN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_WALK: begin
          if (tok_end.live) begin
            res_found_q  <= ~tok_end.put & tok_end.hit_cv;
            res_rd_q     <= tok_end.put ? '0 : rd_w[ENTRIES];
            res_status_q <= (tok_end.put && !tok_end.hit && !tok_end.free_found)
                            ? STAT_FULL : STAT_OK;
            state_q      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_found_q  <= res_found_q;
            out_rd_q     <= res_rd_q;
            out_status_q <= res_status_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_rd_q;
  assign m_axis_tuser_o  = {out_status_q, out_found_q};

  // token leaves the chain only while a get or put is in flight
  `TKVS_ASSERT_IMP(a_tok_idle, state_q != ST_WALK, !tok_end.live, "token outside walk")
  // begin and rollback drops and new-entry writes never coincide with a commit
  `TKVS_ASSERT_IMP(a_bc_excl, bc.commit, !bc.drop && !bc.wr_new, "broadcast clash")
  // a new entry is placed only when the key was absent everywhere
  `TKVS_ASSERT_IMP(a_new_absent, bc.wr_new, in_txn_q && !tok_end.hit, "bad new entry")
  // transaction flag moves only on an accepted command
  `TKVS_ASSERT_NXT(a_txn_hold, !s_accept, $stable(in_txn_q), "txn flag moved")

endmodule

/* src/tkvs_cell.sv */
module tkvs_cell #(
  parameter int unsigned KEY_BITS = tkvs_pkg::KEY_BITS_DEF,
  parameter int unsigned IDX_BITS = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tkvs_pkg::tkvs_tok_t             tok_i,
  input  logic [KEY_BITS-1:0]             key_i,
  input  logic [tkvs_pkg::VALUE_BITS-1:0] value_i,
  input  logic [tkvs_pkg::VALUE_BITS-1:0] rd_i,
  input  logic [IDX_BITS-1:0]             free_idx_i,
  output tkvs_pkg::tkvs_tok_t             tok_o,
  output logic [KEY_BITS-1:0]             key_o,
  output logic [tkvs_pkg::VALUE_BITS-1:0] value_o,
  output logic [tkvs_pkg::VALUE_BITS-1:0] rd_o,
  output logic [IDX_BITS-1:0]             free_idx_o,
  input  tkvs_pkg::tkvs_bcast_t           bc_i,
  input  logic [IDX_BITS-1:0]             wr_idx_i,
  input  logic [KEY_BITS-1:0]             wr_key_i,
  input  logic [tkvs_pkg::VALUE_BITS-1:0] wr_value_i
);
  import tkvs_pkg::*;

  logic                  cv_q, sv_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] cval_q, sval_q;
  tkvs_tok_t             tok_q;
  logic [KEY_BITS-1:0]   pkey_q;
  logic [VALUE_BITS-1:0] pval_q, prd_q;
  logic [IDX_BITS-1:0]   pidx_q;

  logic used, match, wr_sel, put_hit, do_commit;

  assign used      = cv_q | sv_q;
  assign match     = tok_i.live & used & (key_q == key_i);
  assign put_hit   = match & tok_i.put;
  assign wr_sel    = bc_i.wr_new & (wr_idx_i == IDX_BITS'(CELL_IDX));
  assign do_commit = bc_i.commit & sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q  <= 1'b0;
      sv_q  <= 1'b0;
      tok_q <= '0;
    end else begin
      priority if (do_commit) begin
        cv_q <= 1'b1;
        sv_q <= 1'b0;
      end else if (bc_i.drop) begin
        sv_q <= 1'b0;
      end else if (wr_sel || put_hit) begin
        sv_q <= 1'b1;
      end else begin
        sv_q <= sv_q;
      end
      tok_q.live       <= tok_i.live;
      tok_q.put        <= tok_i.put;
      tok_q.hit        <= tok_i.hit | match;
      tok_q.hit_cv     <= tok_i.hit_cv | (match & cv_q);
      tok_q.free_found <= tok_i.free_found | ~used;
    end
  end

  // entry payload and pass-through stage
  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      key_q  <= wr_key_i;
      sval_q <= wr_value_i;
    end else if (put_hit) begin
      sval_q <= value_i;
    end
    if (do_commit) cval_q <= sval_q;
    pkey_q <= key_i;
    pval_q <= value_i;
    prd_q  <= (match & cv_q) ? cval_q : rd_i;
    pidx_q <= tok_i.free_found ? free_idx_i : IDX_BITS'(CELL_IDX);
  end

  assign tok_o      = tok_q;
  assign key_o      = pkey_q;
  assign value_o    = pval_q;
  assign rd_o       = prd_q;
  assign free_idx_o = pidx_q;

endmodule

/* tb/sv/transactional_key_value_store_tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the transactional key/value store.
// Commands go in on the slave stream and replies come back on the master stream.
// A shadow copy of the store predicts one reply per accepted command.
// The opening section walks through the corner cases.
// The random section then runs mostly well-formed begin/put/get/commit or
// rollback sequences over a small key pool, plus stray commands as noise.
module transactional_key_value_store_tb;
  import tkvs_pkg::*;

  localparam int unsigned SLOTS        = ENTRIES_DEF;
  localparam int unsigned RANDOM_CMDS  = 2000;
  localparam int unsigned CALM_TAIL    = 300;   // no idling on either side from here on
  localparam int unsigned DRAIN_CYCLES = SLOTS + 8;
  localparam logic [31:0] KEY_MASK     = (KEY_BITS_DEF >= 32) ? 32'hFFFF_FFFF :
                                         32'((64'd1 << KEY_BITS_DEF) - 64'd1);
  // kind codes the block leaves unused
  localparam logic [KIND_BITS-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    logic         found;
    logic [31:0]  read_value;
    tkvs_status_e status;
  } store_reply_t;

  // Shadow of the store: predicts the reply of every accepted command and
  // holds the replies still owed.
  class store_shadow;
    logic [31:0]  slot_key      [SLOTS];
    logic [31:0]  committed_val [SLOTS];
    logic [31:0]  staged_val    [SLOTS];
    bit           committed_ok  [SLOTS];
    bit           staged_ok     [SLOTS];
    bit           txn_open;
    store_reply_t owed_replies[$];
    int unsigned  errors;
    int unsigned  replies_seen;
    int unsigned  kind_count [8];
    int unsigned  status_count [4];

    function new();
      foreach (committed_ok[i]) begin
        committed_ok[i] = 1'b0;
        staged_ok[i]    = 1'b0;
      end
      txn_open     = 1'b0;
      errors       = 0;
      replies_seen = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function int lookup(logic [31:0] k);
      for (int i = 0; i < SLOTS; i++) begin
        if ((committed_ok[i] || staged_ok[i]) && slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    function int first_free();
      for (int i = 0; i < SLOTS; i++) begin
        if (!committed_ok[i] && !staged_ok[i]) return i;
      end
      return -1;
    endfunction

    function void drop_staged();
      foreach (staged_ok[i]) staged_ok[i] = 1'b0;
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    // accepted command: update the shadow and queue its reply
    function void note_command(logic [KIND_BITS-1:0] kind, logic [31:0] key_in,
                               logic [31:0] value);
      store_reply_t r;
      logic [31:0]  k;
      int           slot;
      r.found      = 1'b0;
      r.read_value = '0;
      r.status     = STAT_OK;
      k = key_in & KEY_MASK;
      case (kind)
        KIND_GET: begin
          slot = lookup(k);
          if (slot >= 0 && committed_ok[slot]) begin
            r.found      = 1'b1;
            r.read_value = committed_val[slot];
          end
        end
        KIND_PUT: begin
          if (!txn_open) begin
            r.status = STAT_NO_TXN;
          end else begin
            slot = lookup(k);
            if (slot < 0) begin
              slot = first_free();
              if (slot >= 0) slot_key[slot] = k;
            end
            if (slot < 0) begin
              r.status = STAT_FULL;
            end else begin
              staged_val[slot] = value;
              staged_ok[slot]  = 1'b1;
            end
          end
        end
        KIND_BEGIN: begin
          if (txn_open) begin
            r.status = STAT_IN_TXN;
          end else begin
            txn_open = 1'b1;
            drop_staged();
          end
        end
        KIND_COMMIT: begin
          if (!txn_open) begin
            r.status = STAT_NO_TXN;
          end else begin
            // staged values overwrite whatever was committed before
            for (int i = 0; i < SLOTS; i++) begin
              if (staged_ok[i]) begin
                committed_val[i] = staged_val[i];
                committed_ok[i]  = 1'b1;
                staged_ok[i]     = 1'b0;
              end
            end
            txn_open = 1'b0;
          end
        end
        KIND_ROLLBACK: begin
          if (!txn_open) begin
            r.status = STAT_NO_TXN;
          end else begin
            drop_staged();
            txn_open = 1'b0;
          end
        end
        default: ;
      endcase
      kind_count[kind]++;
      status_count[r.status]++;
      owed_replies.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] ERROR %s", $time, what);
    endtask

    // accepted reply: compare with the oldest owed one
    task check_reply(logic found, logic [31:0] read_value, logic [STATUS_BITS-1:0] status);
      store_reply_t exp;
      replies_seen++;
      if (owed_replies.size() == 0) begin
        report($sformatf("unexpected reply found=%0b value=%h status=%0d",
                         found, read_value, status));
      end else begin
        exp = owed_replies.pop_front();
        if (found !== exp.found)
          report($sformatf("found %0b, expected %0b", found, exp.found));
        if (read_value !== exp.read_value)
          report($sformatf("read_value %h, expected %h", read_value, exp.read_value));
        if (status !== exp.status)
          report($sformatf("status %0d, expected %s", status, exp.status.name()));
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [63:0]            s_axis_tdata;   // key [31:0], value [63:32]
  logic [KIND_BITS-1:0]   s_axis_tuser;   // kind [2:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [VALUE_BITS-1:0]  m_axis_tdata;   // read_value [31:0]
  logic [STATUS_BITS:0]   m_axis_tuser;   // found [0], status [2:1]

  store_shadow shadow;
  bit          cmd_taken;       // set at the rising edge that accepted a command
  bit          src_idle_on;
  bit          sink_idle_on;
  int unsigned sink_stall_left;
  int unsigned cmds_sent;
  logic [31:0] hot_keys  [12];
  logic [31:0] cold_keys [12];

  transactional_key_value_store u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitors sample at the rising edge, before the block's registers move.
  always @(posedge clk_i) begin
    cmd_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (cmd_taken)
      shadow.note_command(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      shadow.check_reply(m_axis_tuser[0], m_axis_tdata, m_axis_tuser[2:1]);
  end

  // Reply side back-pressure: random bursts of tready low while enabled.
  always @(negedge clk_i) begin
    if (sink_stall_left > 0) begin
      sink_stall_left <= sink_stall_left - 1;
      m_axis_tready   <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      sink_stall_left <= $urandom_range(0, 12);
      m_axis_tready   <= 1'b0;
    end else begin
      m_axis_tready   <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so a back-to-back command keeps it up.
  task automatic issue_cmd(logic [KIND_BITS-1:0] kind, logic [31:0] key,
                           logic [31:0] value);
    int unsigned gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, key};
    s_axis_tuser  <= kind;
    do @(negedge clk_i); while (!cmd_taken);
    cmds_sent++;
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return hot_keys[$urandom_range(0, 11)];
    if (r < 90) return cold_keys[$urandom_range(0, 11)];
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // one well-formed store transaction with random content
  task automatic run_store_txn();
    int unsigned ops;
    issue_cmd(KIND_BEGIN, $urandom(), $urandom());
    ops = $urandom_range(1, 8);
    repeat (ops) begin
      if ($urandom_range(0, 99) < 65) issue_cmd(KIND_PUT, pick_key(), pick_value());
      else issue_cmd(KIND_GET, pick_key(), $urandom());
    end
    if ($urandom_range(0, 9) < 7) issue_cmd(KIND_COMMIT, $urandom(), $urandom());
    else issue_cmd(KIND_ROLLBACK, $urandom(), $urandom());
  endtask

  task automatic run_noise();
    logic [KIND_BITS-1:0] kind;
    if ($urandom_range(0, 9) == 0)
      kind = KIND_BITS'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    else kind = KIND_BITS'($urandom_range(KIND_GET, KIND_ROLLBACK));
    issue_cmd(kind, pick_key(), pick_value());
  endtask

  initial begin
    #5_000_000;
    $display("[%0t] timeout with %0d replies still owed", $time, shadow.pending());
    $display("transactional_key_value_store verification failed");
    $finish;
  end

  initial begin
    int unsigned random_start;
    int unsigned next_phase;
    shadow          = new();
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = KIND_GET;
    m_axis_tready   = 1'b0;
    sink_stall_left = 0;
    src_idle_on     = 1'b0;
    sink_idle_on    = 1'b0;
    cmds_sent       = 0;
    hot_keys[0] = 32'h0000_0000;
    hot_keys[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) hot_keys[i] = $urandom();
    foreach (cold_keys[i]) cold_keys[i] = $urandom();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Opening section, back to back: misuse while closed, unused kinds, then a first commit
    issue_cmd(KIND_GET, 32'h0000_0000, 32'h0000_0000);       // empty store
    issue_cmd(KIND_PUT, 32'h1234_5678, 32'hDEAD_BEEF);       // no store transaction open
    issue_cmd(KIND_COMMIT, 32'h0, 32'h0);
    issue_cmd(KIND_ROLLBACK, 32'h0, 32'h0);
    issue_cmd(KIND_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_cmd(KIND_BEGIN, 32'h0, 32'h0);
    issue_cmd(KIND_BEGIN, 32'h0, 32'h0);                     // already open
    issue_cmd(KIND_PUT, 32'h0000_0000, 32'h8000_0000);
    issue_cmd(KIND_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    issue_cmd(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);       // restage same key
    issue_cmd(KIND_GET, 32'h0000_0000, 32'h0);               // staged only, not visible
    issue_cmd(KIND_COMMIT, 32'h0, 32'h0);
    issue_cmd(KIND_GET, 32'h0000_0000, 32'h0);
    issue_cmd(KIND_GET, 32'hFFFF_FFFF, 32'h0);
    // fill every free slot with staged keys, overflow it, then roll back
    issue_cmd(KIND_BEGIN, 32'h0, 32'h0);
    for (int i = 0; i < SLOTS - 2; i++) issue_cmd(KIND_PUT, 32'h5A00_0000 + i, $urandom());
    issue_cmd(KIND_PUT, 32'hA5A5_A5A5, 32'h1);               // table full
    issue_cmd(KIND_PUT, 32'h0000_0000, 32'h0000_007B);       // existing key still fits
    issue_cmd(KIND_ROLLBACK, 32'h0, 32'h0);                  // frees the staged-only slots
    issue_cmd(KIND_GET, 32'h0000_0000, 32'h0);
    issue_cmd(KIND_GET, 32'h5A00_0000, 32'h0);

    // Random section; idling switches per phase and stops for the tail
    random_start = cmds_sent;
    next_phase   = cmds_sent;
    while (cmds_sent - random_start < RANDOM_CMDS) begin
      if (cmds_sent >= next_phase) begin
        src_idle_on  = ($urandom_range(0, 2) != 0);
        sink_idle_on = ($urandom_range(0, 2) != 0);
        next_phase   = cmds_sent + $urandom_range(80, 200);
      end
      if (cmds_sent - random_start >= RANDOM_CMDS - CALM_TAIL) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      if ($urandom_range(0, 9) < 8) run_store_txn();
      else run_noise();
    end
    s_axis_tvalid <= 1'b0;

    while (shadow.pending() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d commands: %0d get, %0d put, %0d begin, %0d commit, %0d rollback",
             cmds_sent, shadow.kind_count[KIND_GET], shadow.kind_count[KIND_PUT],
             shadow.kind_count[KIND_BEGIN], shadow.kind_count[KIND_COMMIT],
             shadow.kind_count[KIND_ROLLBACK]);
    $display("%0d replies checked; statuses no-txn %0d, already-open %0d, full %0d",
             shadow.replies_seen, shadow.status_count[STAT_NO_TXN],
             shadow.status_count[STAT_IN_TXN], shadow.status_count[STAT_FULL]);
    if (shadow.errors == 0) begin
      $display("transactional_key_value_store verification clean");
    end else begin
      $display("transactional_key_value_store verification failed");
    end
    $finish;
  end

endmodule
